FILE: hdl/rlesd_pkg.sv
package rlesd_pkg;

    localparam int MIN_RANGE_SHORT = (16 + 1 + 1) + 2;
    localparam int RUN_BIAS        = MIN_RANGE_SHORT / 16 - 1;
    localparam int HEADER_BYTES    = 8;
    localparam int SYMBOL_BYTES    = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_DATA_W      = 168;
    localparam int OUT_USER_W      = 2;

    typedef enum logic [2:0] {
        PH_HEADER      = 3'd0,
        PH_SYMBOL      = 3'd1,
        PH_COUNT       = 3'd2,
        PH_COUNT_WIDE  = 3'd3,
        PH_OFFSET      = 3'd4,
        PH_OFFSET_WIDE = 3'd5,
        PH_LITERAL     = 3'd6,
        PH_DONE        = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_RUN     = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        logic        has_lit;
        logic [7:0]  lit;
        logic        has_close;
        logic        is_end;
        logic [63:0] sym_lo;
        logic [63:0] sym_hi;
        logic [31:0] units;
    } t_entry;

endpackage

FILE: hdl/rle_128bit_symbol_stream_decoder.sv
// Run-length stream decoder for 128-bit symbols.
// Input channel (s_axis): one compressed byte per word in tdata; tuser high
// marks the first header byte of a new stream and restarts parsing.
// Output channel (m_axis): tuser carries the word kind (literal, run, end of
// stream); tdata carries literal byte, symbol low, symbol high and run units.
// tlast marks the final output word caused by one input byte.
// One byte is taken per cycle while the queue between parser and output
// stage has room. A byte that closes its literal section gives two output
// words, the literal then the run descriptor or end marker; every other
// byte gives at most one word. Header, symbol and count bytes give none and
// an offset byte gives at most one, so the output side sustains the input
// rate on any real stream. An accepted byte's words are written into the
// queue and then loaded into the output register.
// After reset the parser sits in the header phase as though a stream began
// and the queue and output register are empty. A receiver stall holds the
// output word; the queue absorbs up to QUEUE_DEPTH entries before s_axis
// tready drops. Bytes after the end of a stream give no output.
module rle_128bit_symbol_stream_decoder #(
    parameter int QUEUE_DEPTH = rlesd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // in_byte
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // literal_byte, symbol_low, symbol_high, run_units
    output logic [rlesd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [rlesd_pkg::OUT_USER_W-1:0] o_m_axis_tuser, // kind
    output logic        o_m_axis_tlast    // last_of_item
);
    import rlesd_pkg::*;

    logic   take;
    logic   push, pop, full, head_valid;
    t_entry entry, head;

    assign o_s_axis_tready = !full;
    assign take            = i_s_axis_tvalid && !full;

    rlesd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .o_push  (push),
        .o_entry (entry)
    );

    rlesd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    rlesd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata),
        .o_tuser      (o_m_axis_tuser),
        .o_tlast      (o_m_axis_tlast)
    );

endmodule

FILE: hdl/rlesd_parse.sv
module rlesd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output logic              o_push,
    output rlesd_pkg::t_entry o_entry
);
    import rlesd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_sym_lo, r_sym_hi;
    logic [31:0] r_count, r_rem;

    t_phase      ph;
    logic [3:0]  idx;
    logic [31:0] wide_rem;
    logic        wide_last;
    logic        rem_low;
    t_phase      close_phase;

    assign ph          = i_start ? PH_HEADER : r_phase;
    assign idx         = i_start ? 4'd0 : r_idx;
    assign wide_rem    = {i_byte, r_rem[23:0]};
    assign wide_last   = (idx[1:0] == 2'd3);
    assign rem_low     = (r_rem[31:1] == 31'd0);
    assign close_phase = (r_count == 32'd0) ? PH_DONE : PH_SYMBOL;

    always_comb begin
        n_phase = ph;
        unique case (ph)
            PH_HEADER: begin
                if (idx == 4'(HEADER_BYTES - 1)) n_phase = PH_SYMBOL;
            end
            PH_SYMBOL: begin
                if (idx == 4'(SYMBOL_BYTES - 1)) n_phase = PH_COUNT;
            end
            PH_COUNT: begin
                n_phase = (i_byte == 8'd0) ? PH_COUNT_WIDE : PH_OFFSET;
            end
            PH_COUNT_WIDE: begin
                if (wide_last) n_phase = PH_OFFSET;
            end
            PH_OFFSET: begin
                if (i_byte == 8'd0)      n_phase = PH_OFFSET_WIDE;
                else if (i_byte == 8'd1) n_phase = close_phase;
                else                     n_phase = PH_LITERAL;
            end
            PH_OFFSET_WIDE: begin
                if (wide_last) begin
                    if (wide_rem == 32'd0)      n_phase = PH_DONE;
                    else if (wide_rem == 32'd1) n_phase = close_phase;
                    else                        n_phase = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                if (rem_low) n_phase = close_phase;
            end
            PH_DONE:  n_phase = PH_DONE;
            default:  n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        o_entry.has_lit   = 1'b0;
        o_entry.lit       = i_byte;
        o_entry.has_close = 1'b0;
        o_entry.is_end    = (r_count == 32'd0);
        o_entry.sym_lo    = r_sym_lo;
        o_entry.sym_hi    = r_sym_hi;
        o_entry.units     = r_count + 32'(RUN_BIAS);
        n_idx             = idx;
        unique case (ph)
            PH_HEADER, PH_SYMBOL: begin
                n_idx = (n_phase != ph) ? 4'd0 : idx + 4'd1;
            end
            PH_COUNT_WIDE: begin
                n_idx = wide_last ? 4'd0 : {2'b00, idx[1:0] + 2'd1};
            end
            PH_COUNT: n_idx = 4'd0;
            PH_OFFSET: begin
                n_idx             = 4'd0;
                o_entry.has_close = (i_byte == 8'd1);
            end
            PH_OFFSET_WIDE: begin
                n_idx = wide_last ? 4'd0 : {2'b00, idx[1:0] + 2'd1};
                if (wide_last && wide_rem == 32'd0) begin
                    o_entry.has_close = 1'b1;
                    o_entry.is_end    = 1'b1;
                end else if (wide_last && wide_rem == 32'd1) begin
                    o_entry.has_close = 1'b1;
                end
            end
            PH_LITERAL: begin
                o_entry.has_lit   = 1'b1;
                o_entry.has_close = rem_low;
                if (rem_low) n_idx = 4'd0;
            end
            PH_DONE:  n_idx = idx;
            default:  n_idx = idx;
        endcase
    end

    assign o_push = i_take && (o_entry.has_lit || o_entry.has_close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= 4'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            unique case (ph)
                PH_SYMBOL: begin
                    if (!idx[3]) r_sym_lo[{idx[2:0], 3'b000} +: 8] <= i_byte;
                    else         r_sym_hi[{idx[2:0], 3'b000} +: 8] <= i_byte;
                end
                PH_COUNT:      r_count <= {24'd0, i_byte};
                PH_COUNT_WIDE: r_count[{idx[1:0], 3'b000} +: 8] <= i_byte;
                PH_OFFSET: begin
                    r_rem <= (i_byte == 8'd0) ? 32'd0 : {24'd0, i_byte} - 32'd1;
                end
                PH_OFFSET_WIDE: begin
                    if (wide_last) r_rem <= wide_rem - 32'd1;
                    else           r_rem[{idx[1:0], 3'b000} +: 8] <= i_byte;
                end
                PH_LITERAL: begin
                    if (r_rem != 32'd0) r_rem <= r_rem - 32'd1;
                end
                default: ;
            endcase
        end
    end

    a_header_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_idx < 4'(HEADER_BYTES))
        else $error("header index out of range");

    a_literal_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LITERAL |-> r_rem != 32'd0)
        else $error("literal phase with nothing left");

endmodule

FILE: hdl/rlesd_fifo.sv
module rlesd_fifo #(
    parameter int DEPTH = rlesd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rlesd_pkg::t_entry i_entry,
    input  logic              i_pop,
    output rlesd_pkg::t_entry o_head,
    output logic              o_head_valid,
    output logic              o_full
);
    import rlesd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CNT_W-1:0]   r_count;

    assign n_wptr       = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr       = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    assign o_head       = r_mem[r_rptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= n_wptr;
            if (i_pop)  r_rptr <= n_rptr;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_entry;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");

endmodule

FILE: hdl/rlesd_emit.sv
module rlesd_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlesd_pkg::t_entry i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [rlesd_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic [rlesd_pkg::OUT_USER_W-1:0] o_tuser,
    output logic              o_tlast
);
    import rlesd_pkg::*;

    logic        r_valid, n_valid;
    logic        r_half, n_half;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_lit, n_lit;
    logic [63:0] r_lo, n_lo, r_hi, n_hi;
    logic [31:0] r_units, n_units;
    logic        r_last, n_last;
    logic        load;

    assign load = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        n_kind  = r_kind;
        n_lit   = r_lit;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_units = r_units;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                if (i_head.has_lit && !r_half) begin
                    n_kind  = KIND_LITERAL;
                    n_lit   = i_head.lit;
                    n_lo    = 64'd0;
                    n_hi    = 64'd0;
                    n_units = 32'd0;
                    n_last  = !i_head.has_close;
                    n_half  = i_head.has_close;
                    o_pop   = !i_head.has_close;
                end else begin
                    n_kind  = i_head.is_end ? KIND_END : KIND_RUN;
                    n_lit   = 8'd0;
                    n_lo    = i_head.is_end ? 64'd0 : i_head.sym_lo;
                    n_hi    = i_head.is_end ? 64'd0 : i_head.sym_hi;
                    n_units = i_head.is_end ? 32'd0 : i_head.units;
                    n_last  = 1'b1;
                    n_half  = 1'b0;
                    o_pop   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_lit   <= n_lit;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_units <= n_units;
        r_last  <= n_last;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_units, r_hi, r_lo, r_lit};
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    a_half_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_head_valid && i_head.has_lit && i_head.has_close))
        else $error("split word without a matching queue head");

    a_half_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_valid && r_kind == KIND_LITERAL && !r_last))
        else $error("split word state without pending literal");

endmodule

FILE: tb/rle_decode_checker.sv
module rle_decode_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [7:0]                       i_s_tdata,   // in_byte
    input  logic                             i_s_tuser,   // frame_start
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // literal_byte, symbol_low, symbol_high, run_units
    input  logic [rlesd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [rlesd_pkg::OUT_USER_W-1:0] i_m_tuser,   // kind
    input  logic                             i_m_tlast,
    output int                               o_fail_count,
    output int                               o_pending
);
    import rlesd_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [7:0]  lit;
        logic [63:0] sym_lo;
        logic [63:0] sym_hi;
        logic [31:0] units;
        logic        last;
    } t_out_word;

    t_phase      phase;
    logic [3:0]  byte_pos;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;
    logic [31:0] run_count;
    logic [31:0] lit_left;

    t_out_word   words_due[$];
    t_out_word   step_words[2];
    int          n_step;

    task automatic report(input string what);
        if (o_fail_count < 200) $display("%0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic restart_parser();
        phase     = PH_HEADER;
        byte_pos  = '0;
        sym_lo    = '0;
        sym_hi    = '0;
        run_count = '0;
        lit_left  = '0;
    endtask

    task automatic emit(input t_kind k, input logic [7:0] lit, input logic [63:0] lo,
                        input logic [63:0] hi, input logic [31:0] units);
        step_words[n_step].kind   = k;
        step_words[n_step].lit    = lit;
        step_words[n_step].sym_lo = lo;
        step_words[n_step].sym_hi = hi;
        step_words[n_step].units  = units;
        step_words[n_step].last   = 1'b0;
        n_step++;
    endtask

    task automatic close_record();
        if (run_count == 0) begin
            emit(KIND_END, 8'h00, 64'h0, 64'h0, 32'h0);
            phase = PH_DONE;
        end else begin
            emit(KIND_RUN, 8'h00, sym_lo, sym_hi, run_count + 32'(RUN_BIAS));
            phase    = PH_SYMBOL;
            byte_pos = '0;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic st);
        int pos;
        n_step = 0;
        if (st) restart_parser();
        pos = int'(byte_pos);
        case (phase)
            PH_HEADER: begin
                pos++;
                if (pos >= HEADER_BYTES) begin
                    phase = PH_SYMBOL;
                    pos   = 0;
                end
                byte_pos = 4'(pos);
            end
            PH_SYMBOL: begin
                if (pos == 0) begin
                    sym_lo = '0;
                    sym_hi = '0;
                end
                if (pos < 8) sym_lo = sym_lo | (64'(b) << (8 * pos));
                else sym_hi = sym_hi | (64'(b) << (8 * (pos - 8)));
                pos++;
                if (pos >= SYMBOL_BYTES) begin
                    phase = PH_COUNT;
                    pos   = 0;
                end
                byte_pos = 4'(pos);
            end
            PH_COUNT: begin
                run_count = 32'(b);
                byte_pos  = '0;
                phase     = (b == 0) ? PH_COUNT_WIDE : PH_OFFSET;
            end
            PH_COUNT_WIDE: begin
                pos       = pos & 3;
                run_count = run_count | (32'(b) << (8 * pos));
                pos++;
                if (pos >= 4) begin
                    phase = PH_OFFSET;
                    pos   = 0;
                end
                byte_pos = 4'(pos);
            end
            PH_OFFSET: begin
                byte_pos = '0;
                if (b == 0) begin
                    lit_left = '0;
                    phase    = PH_OFFSET_WIDE;
                end else begin
                    lit_left = 32'(b) - 1;
                    if (lit_left == 0) close_record();
                    else phase = PH_LITERAL;
                end
            end
            PH_OFFSET_WIDE: begin
                pos      = pos & 3;
                lit_left = lit_left | (32'(b) << (8 * pos));
                pos++;
                byte_pos = 4'(pos);
                if (pos >= 4) begin
                    byte_pos = '0;
                    if (lit_left == 0) begin
                        emit(KIND_END, 8'h00, 64'h0, 64'h0, 32'h0);
                        phase = PH_DONE;
                    end else begin
                        lit_left = lit_left - 1;
                        if (lit_left == 0) close_record();
                        else phase = PH_LITERAL;
                    end
                end
            end
            PH_LITERAL: begin
                emit(KIND_LITERAL, b, 64'h0, 64'h0, 32'h0);
                if (lit_left > 0) lit_left = lit_left - 1;
                if (lit_left == 0) close_record();
            end
            default: ;
        endcase
        if (n_step > 0) step_words[n_step - 1].last = 1'b1;
        for (int i = 0; i < n_step; i++) words_due.push_back(step_words[i]);
    endtask

    task automatic check_word();
        t_out_word w;
        if (words_due.size() == 0) begin
            report($sformatf("unexpected output word, kind %0d", i_m_tuser));
            return;
        end
        w = words_due.pop_front();
        if (i_m_tuser !== w.kind)
            report($sformatf("kind %0d, want %0d", i_m_tuser, w.kind));
        if (i_m_tdata[7:0] !== w.lit)
            report($sformatf("literal %h, want %h", i_m_tdata[7:0], w.lit));
        if (i_m_tdata[71:8] !== w.sym_lo)
            report($sformatf("symbol low %h, want %h", i_m_tdata[71:8], w.sym_lo));
        if (i_m_tdata[135:72] !== w.sym_hi)
            report($sformatf("symbol high %h, want %h", i_m_tdata[135:72], w.sym_hi));
        if (i_m_tdata[167:136] !== w.units)
            report($sformatf("run units %h, want %h", i_m_tdata[167:136], w.units));
        if (i_m_tlast !== w.last)
            report($sformatf("tlast %b, want %b", i_m_tlast, w.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parser();
            words_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_word();
            if (i_s_tvalid && i_s_tready) parse_byte(i_s_tdata, i_s_tuser);
        end
        o_pending <= words_due.size();
    end

endmodule

FILE: tb/tb.sv
module tb;
    import rlesd_pkg::*;

    localparam int LIMIT = 400000;
    localparam int ITEMS = 1400;
    localparam int HOLD  = 300;

    typedef struct {
        logic [7:0] b;
        logic       st;
    } t_in_byte;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    int       fail_count;
    int       words_pending;
    int       cycles = 0;
    int       sent = 0;
    bit       idle_on = 1'b1;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    t_in_byte stream_bytes[$];

    rle_128bit_symbol_stream_decoder i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    rle_decode_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD) @(negedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add(input logic [7:0] b, input logic st);
        t_in_byte x;
        x.b  = b;
        x.st = st;
        stream_bytes.push_back(x);
    endtask

    task automatic add_rand(input int n);
        repeat (n) add(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic add_word32(input logic [31:0] v);
        for (int i = 0; i < 4; i++) add(v[8 * i +: 8], 1'b0);
    endtask

    task automatic add_header(input logic st);
        add(8'($urandom_range(0, 255)), st);
        add_rand(HEADER_BYTES - 1);
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones
    task automatic add_symbol(input int fill);
        for (int i = 0; i < SYMBOL_BYTES; i++)
            add((fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic add_field(input logic [31:0] v, input bit wide);
        if (wide) begin
            add(8'h00, 1'b0);
            add_word32(v);
        end else begin
            add(v[7:0], 1'b0);
        end
    endtask

    task automatic add_record(input int fill, input logic [31:0] cnt, input bit cwide,
                              input logic [31:0] off, input bit owide);
        add_symbol(fill);
        add_field(cnt, cwide);
        add_field(off, owide);
        if (off != 0) add_rand(int'(off - 1));
    endtask

    task automatic random_record();
        logic [31:0] cnt;
        logic [31:0] off;
        bit          cwide;
        bit          owide;
        int          r;
        r     = $urandom_range(0, 9);
        cwide = (r >= 6);
        case (r)
            6:       cnt = 32'hFFFF_FFFF;
            7:       cnt = $urandom_range(1, 255);
            8:       cnt = $urandom();
            9:       cnt = $urandom_range(1, 4);
            default: cnt = $urandom_range(1, 255);
        endcase
        if (cnt == 0) cnt = 32'd1;
        r     = $urandom_range(0, 19);
        owide = (r >= 15 && r <= 18);
        if (r < 12) off = $urandom_range(1, 10);
        else if (r < 15) off = $urandom_range(11, 255);
        else if (r < 19) off = $urandom_range(1, 24);
        else off = 32'd1;
        r = $urandom_range(0, 9);
        add_record((r == 0) ? 1 : (r == 1) ? 2 : 0, cnt, cwide, off, owide);
    endtask

    task automatic random_stream();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            repeat ($urandom_range(1, 20))
                add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (r == 1) begin
            add_header(1'b1);
            random_record();
            repeat ($urandom_range(1, 10))
                if (stream_bytes.size() > HEADER_BYTES) void'(stream_bytes.pop_back());
        end else if (r == 2) begin
            add_header(1'b1);
            add_symbol(0);
            add_field($urandom_range(1, 255), 1'b0);
            add_field($urandom() | 32'h100, 1'b1);
            add_rand($urandom_range(0, 12));
        end else begin
            add_header(1'b1);
            repeat ($urandom_range(1, 4)) random_record();
            if ($urandom_range(0, 2) == 0) begin
                add_record(0, 32'h0, 1'b1, $urandom_range(1, 8), 1'b0);
            end else begin
                add_symbol(0);
                add_field($urandom_range(1, 255), 1'b0);
                add_field(32'h0, 1'b1);
            end
            add_rand($urandom_range(0, 5));
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic st);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge clk); while (!s_tready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_stream();
        t_in_byte x;
        while (stream_bytes.size() > 0) begin
            x = stream_bytes.pop_front();
            put_byte(x.b, x.st);
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        rst_n    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // first stream arrives with no frame start after reset
        add_header(1'b0);
        add_record(1, 32'd1, 1'b0, 32'd1, 1'b0);
        add_symbol(2);
        add_field(32'hFFFF_FFFF, 1'b1);
        add_field(32'd3, 1'b0);
        add(8'h00, 1'b0);
        add(8'hFF, 1'b0);
        add_record(0, 32'd255, 1'b0, 32'd2, 1'b1);
        add_record(0, 32'd0, 1'b1, 32'd2, 1'b0);
        add_rand(3);
        // wide offset of zero ends at once
        add_header(1'b1);
        add_record(0, 32'd5, 1'b0, 32'd0, 1'b1);
        add_rand(2);
        // count zero with no literals
        add_header(1'b1);
        add_record(0, 32'd0, 1'b1, 32'd1, 1'b0);
        send_stream();

        while (sent < ITEMS) begin
            if (sent > ITEMS * 4 / 5) idle_on = 1'b0;
            if (!hold_done && sent > ITEMS / 3) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                add_header(1'b1);
                add_record(0, $urandom_range(1, 255), 1'b0, 32'd120, 1'b0);
                add_record(0, $urandom_range(1, 255), 1'b0, 32'd120, 1'b0);
            end else begin
                random_stream();
            end
            send_stream();
        end
        s_tvalid <= 1'b0;

        while (words_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
